// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: command codes and the queue entry type.
// Used by rau_front, rau_back and rational_arithmetic_unit.
`default_nettype none
package rau_pkg;
  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_EQ  = 4'd4;
  localparam logic [3:0] CMD_NE  = 4'd5;
  localparam logic [3:0] CMD_LT  = 4'd6;
  localparam logic [3:0] CMD_LE  = 4'd7;
  localparam logic [3:0] CMD_GT  = 4'd8;
  localparam logic [3:0] CMD_GE  = 4'd9;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rau_front.sv =====
// Front part: accepts items, fixes zero denominators and holds them in a two-entry queue.
// Depends on rau_pkg.
`default_nettype none
module rau_front import rau_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [3:0]        command,
  input  wire logic signed [31:0] a_num,
  input  wire logic [30:0]       a_den,
  input  wire logic signed [31:0] b_num,
  input  wire logic [30:0]       b_den,
  output logic                   full,
  output logic                   q_valid,
  output item_t                  q_item,
  input  wire logic              pop
);
  item_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       in_item;

  always_comb begin
    in_item.command = command;
    in_item.a_num   = a_num;
    in_item.a_den   = (a_den == 31'd0) ? 31'd1 : a_den;
    in_item.b_num   = b_num;
    in_item.b_den   = (b_den == 31'd0) ? 31'd1 : b_den;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && q_valid) ? 1 : 0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("full queue with pointers apart");
endmodule
`default_nettype wire

// ===== hw/rtl/rau_back.sv =====
// Back part: cross products, binary-search-free Euclid by shift-subtract remainder,
// and exact division by the GCD. Depends on rau_pkg.
`default_nettype none
module rau_back import rau_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire item_t        q_item,
  output logic              pop,
  output logic              done,
  output logic signed [63:0] res_num,
  output logic [61:0]       res_den,
  output logic              relation_true,
  output logic              div_zero
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_FORM = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_DIVN = 4'd6;
  localparam logic [3:0] S_DIVD = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state;
  item_t              it;
  logic signed [63:0] left;
  logic signed [63:0] right;
  logic signed [63:0] prod_n;
  logic [63:0]        prod_d;
  logic               neg;
  logic [63:0]        mn;
  logic [63:0]        md;
  logic [63:0]        gy;
  // remainder / division datapath
  logic [63:0]        rem;
  logic [63:0]        quo;
  logic [63:0]        dvd;
  logic [6:0]         bitc;
  logic               rem_mode;
  logic [64:0]        trial;
  logic [64:0]        rem_sh;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign rem_sh = {rem, dvd[63]};
  assign trial  = rem_sh - {1'b0, gy};

  always_comb begin
    mul_a = it.a_num;
    mul_b = {1'b0, it.b_den};
    case (state)
      S_M1: begin mul_a = it.a_num; mul_b = {1'b0, it.b_den}; end
      S_M2: begin mul_a = it.b_num; mul_b = {1'b0, it.a_den}; end
      S_M3: begin mul_a = it.a_num; mul_b = it.b_num; end
      default: begin mul_a = {1'b0, it.a_den}; mul_b = {1'b0, it.b_den}; end
    endcase
  end

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            it    <= q_item;
            state <= S_M1;
          end
        end
        S_M1: begin left <= mul_p; state <= S_M2; end
        S_M2: begin right <= mul_p; state <= S_M3; end
        S_M3: begin prod_n <= mul_p; state <= S_FORM; end
        S_FORM: begin
          prod_d        <= mul_p;
          relation_true <= 1'b0;
          div_zero      <= 1'b0;
          res_num       <= 64'sd0;
          res_den       <= 62'd1;
          state         <= S_OUT;
          case (it.command)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              logic signed [63:0] n;
              logic signed [63:0] d;
              n = left + right;
              d = mul_p;
              if (it.command == CMD_SUB) n = left - right;
              if (it.command == CMD_MUL) n = prod_n;
              if (it.command == CMD_DIV) begin
                n = left;
                d = right;
              end
              if (it.command == CMD_DIV && it.b_num == 32'sd0) begin
                div_zero <= 1'b1;
              end else if (n != 64'sd0 && d != 64'sd0) begin
                neg      <= n[63] ^ d[63];
                mn       <= n[63] ? 64'd0 - 64'(n) : 64'(n);
                md       <= d[63] ? 64'd0 - 64'(d) : 64'(d);
                gy       <= d[63] ? 64'd0 - 64'(d) : 64'(d);
                dvd      <= n[63] ? 64'd0 - 64'(n) : 64'(n);
                rem      <= 64'd0;
                bitc     <= 7'd64;
                rem_mode <= 1'b1;
                state    <= S_GCD;
              end
            end
            CMD_EQ: relation_true <= (left == right);
            CMD_NE: relation_true <= (left != right);
            CMD_LT: relation_true <= (left < right);
            CMD_LE: relation_true <= (left <= right);
            CMD_GT: relation_true <= (left > right);
            CMD_GE: relation_true <= (left >= right);
            default: relation_true <= 1'b0;
          endcase
        end
        S_GCD: begin
          // one remainder bit per cycle: rem = dividend % gy
          if (!trial[64]) rem <= trial[63:0];
          else rem <= rem_sh[63:0];
          dvd  <= {dvd[62:0], 1'b0};
          bitc <= bitc - 7'd1;
          if (bitc == 7'd1) begin
            if ((trial[64] ? rem_sh[63:0] : trial[63:0]) == 64'd0) begin
              dvd   <= mn;
              rem   <= 64'd0;
              quo   <= 64'd0;
              bitc  <= 7'd64;
              state <= S_DIVN;
            end else begin
              gy    <= trial[64] ? rem_sh[63:0] : trial[63:0];
              dvd   <= gy;
              rem   <= 64'd0;
              bitc  <= 7'd64;
            end
          end
        end
        S_DIVN, S_DIVD: begin
          if (!trial[64]) rem <= trial[63:0];
          else rem <= rem_sh[63:0];
          quo  <= {quo[62:0], !trial[64]};
          dvd  <= {dvd[62:0], 1'b0};
          bitc <= bitc - 7'd1;
          if (bitc == 7'd1) begin
            rem  <= 64'd0;
            quo  <= 64'd0;
            bitc <= 7'd64;
            if (state == S_DIVN) begin
              res_num <= neg ? 64'd0 - {quo[62:0], !trial[64]}
                             : {quo[62:0], !trial[64]};
              dvd     <= md;
              state   <= S_DIVD;
            end else begin
              res_den <= {quo[60:0], !trial[64]};
              state   <= S_OUT;
            end
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_OUT)
    else $error("result strobe without output step");
  assert property (@(posedge clk) disable iff (rst) pop |=> state == S_M1)
    else $error("popped item not started");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD) |-> gy != 64'd0)
    else $error("zero divisor in gcd");
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: front queue and back execution engine.
// Depends on rau_pkg, rau_front, rau_back.
//
// channel  | handshake          | fields
// input    | start / busy       | command a_num a_den b_num b_den
// result   | res_valid (strobe) | res_num res_den relation_true div_zero
//
// A relation or trivial item, once popped, steps through M1, M2, M3, FORM and OUT before its result strobe.
// Arithmetic runs one bit-serial remainder pass per Euclid step (up to about 92 steps on
// 64-bit magnitudes), then two exact bit-serial divisions for the numerator and the denominator.
// Reset clears the queue and the engine; no memory sweep.
// busy rises while the two-entry queue is full; results cannot be held off.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         command,
  input  wire logic signed [31:0] a_num,
  input  wire logic [30:0]        a_den,
  input  wire logic signed [31:0] b_num,
  input  wire logic [30:0]        b_den,
  output logic                    res_valid,
  output logic signed [63:0]      res_num,
  output logic [61:0]             res_den,
  output logic                    relation_true,
  output logic                    div_zero
);
  logic  q_valid;
  logic  pop;
  item_t q_item;

  rau_front u_front (
    .clk(clk), .rst(rst), .push(start),
    .command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .full(busy), .q_valid(q_valid), .q_item(q_item), .pop(pop)
  );

  rau_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .done(res_valid), .res_num(res_num), .res_den(res_den),
    .relation_true(relation_true), .div_zero(div_zero)
  );
endmodule
`default_nettype wire
